// File: hw/rtl/lprl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Longest prefix route lookup package
// Shared widths, command codes and the item record that moves along the
// chain of route cells.
// ----------------------------------------------------------------------------
package lprl_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned PortWidth  = 8;
  localparam int unsigned CountWidth = 7;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // One item in flight. For a load, addr/mask/hop/port carry the new route.
  // For a lookup, addr is the destination and mask/hop/port/hit carry the
  // best match found so far.
  typedef struct packed {
    logic                  valid;
    cmd_e                  cmd;
    logic [IndexWidth-1:0] idx;
    logic [AddrWidth-1:0]  addr;
    logic [AddrWidth-1:0]  mask;
    logic [AddrWidth-1:0]  hop;
    logic [PortWidth-1:0]  port;
    logic                  hit;
  } item_t;

endpackage
`default_nettype wire

// File: hw/rtl/longest_prefix_route_lookup_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Longest prefix route lookup core
// IPv4 route table of TABLE_DEPTH slots searched by a chain of route cells.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel. tuser selects a load (0) or a lookup (1).
// A load writes one route slot and gives no result; a lookup gives one result
// on m_axis with the longest matching mask, ties going to the higher slot.
// Items travel down one cell per cycle while the chain is not held, so a load
// only affects items behind it. One item per cycle is taken while the result
// side keeps up, as the cell chain advances one stage per cycle.
// The cfg channel writes entries_in_use (slots taking part in lookups); it is
// always ready and should be written only while no item is in flight.
// Reset clears entries_in_use and all stage valid flags; route slots are
// undefined until loaded. When m_axis_tready is low with a result waiting, the
// whole chain holds and s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_core #(
  parameter int unsigned TABLE_DEPTH = lprl_pkg::TableDepth
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Configuration: entries_in_use
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [lprl_pkg::CountWidth-1:0]      cfg_data_i,
  // Input items
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, low bit up: entry_index[5:0], route_prefix[37:6], route_mask[69:38],
  // route_next_hop[101:70], route_port[109:102], dest_addr[141:110], zero[143:142]
  input  wire  [143:0]                         s_axis_tdata,
  // tuser: command
  input  wire                                  s_axis_tuser,
  // Result items
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // tdata, low bit up: hop_addr[31:0], out_port[39:32], matched_mask[71:40]
  output logic [71:0]                          m_axis_tdata,
  // tuser: found
  output logic                                 m_axis_tuser
);

  logic                              advance;
  logic [lprl_pkg::CountWidth-1:0]   count_q;
  lprl_pkg::item_t                   chain [TABLE_DEPTH+1];
  lprl_pkg::item_t                   in_item;
  lprl_pkg::item_t                   last_item;
  logic                              out_valid_q;
  logic                              found_q;
  logic [lprl_pkg::AddrWidth-1:0]    hop_q;
  logic [lprl_pkg::PortWidth-1:0]    port_q;
  logic [lprl_pkg::AddrWidth-1:0]    mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  always_comb begin
    in_item       = '0;
    in_item.valid = s_axis_tvalid;
    in_item.cmd   = lprl_pkg::cmd_e'(s_axis_tuser);
    in_item.idx   = s_axis_tdata[5:0];
    if (in_item.cmd == lprl_pkg::CMD_LOOKUP) begin
      // A lookup starts with no match and zero best fields, which is the miss answer.
      in_item.addr = s_axis_tdata[141:110];
    end else begin
      in_item.addr = s_axis_tdata[37:6];
      in_item.mask = s_axis_tdata[69:38];
      in_item.hop  = s_axis_tdata[101:70];
      in_item.port = s_axis_tdata[109:102];
    end
  end

  assign chain[0] = in_item;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    lprl_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .count_i   (count_q),
      .item_i    (chain[k]),
      .item_o    (chain[k+1])
    );
  end

  assign last_item = chain[TABLE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= last_item.valid && (last_item.cmd == lprl_pkg::CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q <= last_item.hit;
      hop_q   <= last_item.hop;
      port_q  <= last_item.port;
      mask_q  <= last_item.mask;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = {mask_q, port_q, hop_q};

  // A miss carries all-zero route fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss result carries nonzero route fields");

  // A load leaving the chain never turns into a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_item.valid && (last_item.cmd == lprl_pkg::CMD_LOAD))
    |=> !m_axis_tvalid)
    else $error("load produced a result");

  // With no slots in use nothing can match.
  a_no_slots_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (count_q != '0))
    else $error("hit reported with no slots in use");

endmodule
`default_nettype wire

// File: hw/rtl/lprl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route cell
// Holds one route table slot and one pipeline stage. A load written to this
// slot updates the stored route; a lookup is compared against an in-use route and
// takes it over as its best match when it matches with a mask at least as long.
// ----------------------------------------------------------------------------
module lprl_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  advance_i,
  input  wire  [lprl_pkg::CountWidth-1:0]      count_i,
  input  lprl_pkg::item_t                      item_i,
  output lprl_pkg::item_t                      item_o
);

  logic [lprl_pkg::AddrWidth-1:0] prefix_q;
  logic [lprl_pkg::AddrWidth-1:0] mask_q;
  logic [lprl_pkg::AddrWidth-1:0] hop_q;
  logic [lprl_pkg::PortWidth-1:0] port_q;

  logic            active;
  logic            write_en;
  logic            match;
  logic            take;
  logic            valid_q;
  lprl_pkg::item_t item_d;
  lprl_pkg::item_t item_q;

  assign active   = 32'(count_i) > 32'(CellIdx);
  assign write_en = advance_i && item_i.valid && (item_i.cmd == lprl_pkg::CMD_LOAD) &&
                    (32'(item_i.idx) == 32'(CellIdx));
  assign match    = (item_i.addr & mask_q) == (prefix_q & mask_q);
  // Equal masks go to this cell, since it sits at a higher slot than any before it.
  assign take     = (item_i.cmd == lprl_pkg::CMD_LOOKUP) && active && match &&
                    (!item_i.hit || (mask_q >= item_i.mask));

  always_comb begin
    item_d = item_i;
    if (take) begin
      item_d.hit  = 1'b1;
      item_d.mask = mask_q;
      item_d.hop  = hop_q;
      item_d.port = port_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      prefix_q <= item_i.addr;
      mask_q   <= item_i.mask;
      hop_q    <= item_i.hop;
      port_q   <= item_i.port;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= item_i.valid;
    end
  end

  always_comb begin
    item_o       = item_q;
    item_o.valid = valid_q;
  end

endmodule
`default_nettype wire
